// File: src/assert_macros.svh
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold whenever reset is low
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent on the next clock
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/nhrf_pkg.sv
// ----------------------------------------------------------------------------
// nhrf_pkg
// shared types and constants of the newton root finder
// ----------------------------------------------------------------------------
package nhrf_pkg;
  localparam int DEGREE_DEF    = 2;
  localparam int FRAC_BITS_DEF = 16;
  localparam int QW   = 32;
  localparam int KW   = 17;
  localparam int TOLW = 16;
  localparam logic [KW-1:0] LIMIT_CAP = 17'd131070;

  localparam logic [1:0] OUT_CONV  = 2'd0;
  localparam logic [1:0] OUT_LIMIT = 2'd1;
  localparam logic [1:0] OUT_ZDER  = 2'd2;

  localparam logic [2:0] REG_C0  = 3'd0;
  localparam logic [2:0] REG_C1  = 3'd1;
  localparam logic [2:0] REG_C2  = 3'd2;
  localparam logic [2:0] REG_TOL = 3'd3;
  localparam logic [2:0] REG_LIM = 3'd4;

  localparam logic signed [QW-1:0] QMAX = 32'sh7fffffff;
  localparam logic signed [QW-1:0] QMIN = 32'sh80000000;

  typedef struct packed {
    logic signed [QW-1:0] c0;
    logic signed [QW-1:0] c1;
    logic signed [QW-1:0] c2;
    logic [TOLW-1:0]      tol;
    logic [KW-1:0]        lim;
  } cfg_t;

  function automatic logic signed [QW-1:0] sat_w(input logic signed [QW+1:0] v);
    if (v > $signed({{2{1'b0}}, QMAX})) return QMAX;
    if (v < $signed({{2{1'b1}}, QMIN})) return QMIN;
    return v[QW-1:0];
  endfunction
endpackage

// File: src/nhrf_if.sv
// ----------------------------------------------------------------------------
// nhrf_in_if / nhrf_out_if
// valid/ready channels of the root finder
// ----------------------------------------------------------------------------
interface nhrf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_start;
  modport source (output valid, output x_start, input ready);
  modport sink (input valid, input x_start, output ready);
endinterface

interface nhrf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] root;
  logic [16:0] steps_taken;
  logic [1:0]  outcome;
  modport source (output valid, output root, output steps_taken, output outcome, input ready);
  modport sink (input valid, input root, input steps_taken, input outcome, output ready);
endinterface

// File: src/nhrf_div.sv
// ----------------------------------------------------------------------------
// nhrf_div
// radix-2 signed divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module nhrf_div #(
  parameter int FRAC_BITS = nhrf_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [nhrf_pkg::QW-1:0] num,
  input  logic signed [nhrf_pkg::QW-1:0] den,
  output logic                         done,
  output logic signed [nhrf_pkg::QW-1:0] quot
);
  import nhrf_pkg::*;
  localparam int NW = QW + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] n_mag;
  logic [QW-1:0] d_mag;
  logic [QW:0]   rem;
  logic [NW-1:0] q;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          neg;
  logic [QW:0]   trial;
  logic [QW+1:0] qs;

  assign trial = {rem[QW-1:0], n_mag[NW-1]} - {1'b0, d_mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CW'(NW);
        neg   <= num[QW-1] ^ den[QW-1];
        n_mag <= {(num[QW-1] ? QW'(-num) : QW'(num)), {FRAC_BITS{1'b0}}};
        d_mag <= den[QW-1] ? QW'(-den) : QW'(den);
        rem   <= '0;
        q     <= '0;
      end else if (busy) begin
        if (!trial[QW]) begin
          rem <= trial;
          q   <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= {rem[QW-1:0], n_mag[NW-1]};
          q   <= {q[NW-2:0], 1'b0};
        end
        n_mag <= {n_mag[NW-2:0], 1'b0};
        cnt   <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // magnitude saturated to 33 bits before sign applied
  always_comb begin
    logic [QW:0] m;
    if (|q[NW-1:QW]) m = {1'b1, {QW{1'b0}}};
    else m = {1'b0, q[QW-1:0]};
    qs = neg ? -{1'b0, m} : {1'b0, m};
    quot = sat_w(qs);
  end
endmodule

// File: src/nhrf_mac.sv
// ----------------------------------------------------------------------------
// nhrf_mac
// shared multiply-accumulate: sat(addend + floor(a*b >> FRAC_BITS)), registered
// ----------------------------------------------------------------------------
module nhrf_mac #(
  parameter int FRAC_BITS = nhrf_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic signed [nhrf_pkg::QW-1:0] a,
  input  logic signed [nhrf_pkg::QW-1:0] b,
  input  logic signed [nhrf_pkg::QW-1:0] addend,
  output logic signed [nhrf_pkg::QW-1:0] res
);
  import nhrf_pkg::*;
  logic signed [2*QW-1:0] prod;
  logic signed [QW-1:0]   prod_q;
  logic signed [QW-1:0]   add_q;
  logic signed [2*QW-1:0] sh;

  assign sh = prod >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    prod   <= a * b;
    add_q  <= addend;
  end

  always_comb begin
    if (sh > $signed({{QW{1'b0}}, QMAX})) prod_q = QMAX;
    else if (sh < $signed({{QW{1'b1}}, QMIN})) prod_q = QMIN;
    else prod_q = sh[QW-1:0];
  end

  always_ff @(posedge clk) begin
    res <= sat_w({{2{add_q[QW-1]}}, add_q} + {{2{prod_q[QW-1]}}, prod_q});
  end
endmodule

// File: src/newton_horner_root_finder.sv
// newton root finder for a configured quadratic, signed fixed point
// each step runs a horner pass at x0, a division on the bit-serial divider and a
// horner pass at x1, both passes on the shared mac; a limit stop ends a step after
// its division, a zero slope stop ends it before the division
// throughput: one transaction at a time, ready again once the result is taken
// reset (synchronous, active high) clears control and loads default registers
// ----------------------------------------------------------------------------
// newton_horner_root_finder
// newton iteration with horner evaluation on one shared mac and one divider
// ----------------------------------------------------------------------------
module newton_horner_root_finder #(
  parameter int DEGREE    = nhrf_pkg::DEGREE_DEF,
  parameter int FRAC_BITS = nhrf_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  nhrf_in_if.sink     in_ch,
  nhrf_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import nhrf_pkg::*;
  `include "assert_macros.svh"

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HISS  = 4'd1;  // issue horner term
  localparam logic [3:0] S_HW1   = 4'd2;
  localparam logic [3:0] S_HW2   = 4'd3;  // mac result ready
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_DWAIT = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_TEST  = 4'd8;

  cfg_t cfg;
  logic [3:0] state;
  logic signed [QW-1:0] x0, x1, hx, bval, cval;
  logic [KW-1:0] k, lim;
  logic [1:0] hi;        // horner index
  logic hsub;            // 0 value term, 1 derivative term
  logic pass2;           // second horner pass on x1
  logic signed [QW-1:0] mac_a, mac_b, mac_add, mac_res;
  logic div_start, div_done;
  logic signed [QW-1:0] quot;
  logic signed [QW+1:0] dx;
  logic signed [QW:0] adx, apv;
  logic [31:0] root_r;
  logic [KW-1:0] steps_r;
  logic [1:0] outc_r;

  // ---- configuration port, writes at access phase ----
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.c0  <= 32'sd131072;
      cfg.c1  <= 32'sd262144;
      cfg.c2  <= -32'sd65536;
      cfg.tol <= 16'd1;
      cfg.lim <= 17'd100000;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_C0:  cfg.c0  <= pwdata;
        REG_C1:  cfg.c1  <= pwdata;
        REG_C2:  cfg.c2  <= pwdata;
        REG_TOL: cfg.tol <= pwdata[TOLW-1:0];
        REG_LIM: cfg.lim <= pwdata[KW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_C0:  prdata = cfg.c0;
      REG_C1:  prdata = cfg.c1;
      REG_C2:  prdata = cfg.c2;
      REG_TOL: prdata = {16'd0, cfg.tol};
      REG_LIM: prdata = {15'd0, cfg.lim};
      default: prdata = '0;
    endcase
  end

  function automatic logic signed [QW-1:0] coef_at(input logic [1:0] i, input cfg_t c);
    case (i)
      2'd0:    return c.c0;
      2'd1:    return c.c1;
      default: return c.c2;
    endcase
  endfunction

  // ---- shared datapath units ----
  // value term: b = coef[hi] + x*b ; derivative term: c = b + x*c
  assign mac_a   = hx;
  assign mac_b   = hsub ? cval : bval;
  assign mac_add = hsub ? bval : coef_at(hi, cfg);

  nhrf_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .a(mac_a), .b(mac_b), .addend(mac_add), .res(mac_res)
  );

  nhrf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(bval), .den(cval),
    .done(div_done), .quot(quot)
  );

  assign div_start = (state == S_DIV);
  assign dx  = {{2{x1[QW-1]}}, x1} - {{2{x0[QW-1]}}, x0};
  assign adx = dx[QW+1] ? (QW+1)'(0) - dx[QW:0] : dx[QW:0];
  assign apv = bval[QW-1] ? -{bval[QW-1], bval} : {bval[QW-1], bval};

  assign in_ch.ready        = (state == S_IDLE);
  assign out_ch.valid       = (state == S_OUT);
  assign out_ch.root        = root_r;
  assign out_ch.steps_taken = steps_r;
  assign out_ch.outcome     = outc_r;

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          x0    <= in_ch.x_start;
          hx    <= in_ch.x_start;
          k     <= '0;
          lim   <= (cfg.lim > LIMIT_CAP) ? LIMIT_CAP : cfg.lim;
          pass2 <= 1'b0;
          hi    <= 2'(DEGREE - 1);
          hsub  <= 1'b0;
          bval  <= coef_at(2'(DEGREE), cfg);
          cval  <= coef_at(2'(DEGREE), cfg);
          state <= S_HISS;
        end
        S_HISS:  state <= S_HW1;
        S_HW1:   state <= S_HW2;
        S_HW2: begin
          // walk value then derivative term for each index down to 1, then value term at 0
          if (!hsub) begin
            bval <= mac_res;
            if (hi != 2'd0) begin
              hsub  <= 1'b1;
              state <= S_HISS;
            end else if (pass2) state <= S_TEST;
            else state <= S_CHK;
          end else begin
            cval  <= mac_res;
            hsub  <= 1'b0;
            hi    <= hi - 1'b1;
            state <= S_HISS;
          end
        end
        S_CHK: begin
          if (cval == '0) begin
            root_r  <= x0;
            steps_r <= k;
            outc_r  <= OUT_ZDER;
            state   <= S_OUT;
          end else state <= S_DIV;
        end
        S_DIV:   state <= S_DWAIT;
        S_DWAIT: if (div_done) begin
          x1 <= sat_w({{2{x0[QW-1]}}, x0} - {{2{quot[QW-1]}}, quot});
          hx <= sat_w({{2{x0[QW-1]}}, x0} - {{2{quot[QW-1]}}, quot});
          if (k > lim) begin
            root_r  <= sat_w({{2{x0[QW-1]}}, x0} - {{2{quot[QW-1]}}, quot});
            steps_r <= k;
            outc_r  <= OUT_LIMIT;
            state   <= S_OUT;
          end else begin
            k     <= k + 1'b1;
            pass2 <= 1'b1;
            hi    <= 2'(DEGREE - 1);
            hsub  <= 1'b0;
            bval  <= coef_at(2'(DEGREE), cfg);
            cval  <= coef_at(2'(DEGREE), cfg);
            state <= S_HISS;
          end
        end
        S_TEST: begin
          if (adx < {17'd0, cfg.tol} && apv < {17'd0, cfg.tol}) begin
            root_r  <= x1;
            steps_r <= k;
            outc_r  <= OUT_CONV;
            state   <= S_OUT;
          end else begin
            // next step from x1; value and derivative at x1 are recomputed
            x0    <= x1;
            hx    <= x1;
            pass2 <= 1'b0;
            hi    <= 2'(DEGREE - 1);
            hsub  <= 1'b0;
            bval  <= coef_at(2'(DEGREE), cfg);
            cval  <= coef_at(2'(DEGREE), cfg);
            state <= S_HISS;
          end
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHK_ALWAYS(a_steps_bound, !(state == S_OUT) || steps_r <= LIMIT_CAP + 17'd1, "step count past cap")
  `CHK_NEXT(a_out_hold, state == S_OUT && !out_ch.ready, state == S_OUT, "result dropped")
  `CHK_ALWAYS(a_conv_code, !(state == S_OUT) || outc_r != 2'd3, "bad outcome code")
endmodule
